// ----- hw/rtl/mvs_pkg.sv -----
// Shared widths, constants and types of the window statistics block.
`timescale 1ns / 1ps

package mvs_pkg;

   // Sample format and window limit.
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_SAMPLES = 65536;

   // Accumulator widths: count holds MAX_SAMPLES itself.
   localparam int COUNT_BITS = 17;
   localparam int SUM_BITS   = 33;
   localparam int SQSUM_BITS = 47;

   // Result widths.
   localparam int MEAN_BITS = 16;
   localparam int VAR_BITS  = 32;
   localparam int SD_BITS   = 16;

   // Shared arithmetic unit and sequencer widths.
   localparam int WORK_BITS = 64;
   localparam int MAG_BITS  = 32;
   localparam int DEN_BITS  = 33;
   localparam int REM_BITS  = 34;
   localparam int ITER_BITS = 7;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [MEAN_BITS-1:0]   mean_type;
   typedef logic [VAR_BITS-1:0]           variance_type;
   typedef logic [SD_BITS-1:0]            std_dev_type;

endpackage

// ----- hw/rtl/mvs_channels.sv -----
// Valid/ready channel interfaces for sample, result and control words.
`timescale 1ns / 1ps

interface mvs_req_if;
   import mvs_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;
   logic       last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface mvs_rsp_if;
   import mvs_pkg::*;

   logic         valid;
   logic         ready;
   mean_type     mean;
   variance_type variance;
   std_dev_type  std_dev;
   logic         degenerate;

   modport source (output valid, output mean, output variance, output std_dev,
                   output degenerate, input ready);
   modport sink   (input valid, input mean, input variance, input std_dev,
                   input degenerate, output ready);
endinterface

interface mvs_csr_if;
   logic valid;
   logic ready;
   logic population_mode;

   modport source (output valid, output population_mode, input ready);
   modport sink   (input valid, input population_mode, output ready);
endinterface

// ----- hw/rtl/mean_variance_stddev.sv -----
// Window mean, variance and standard deviation over Q8.8 samples.
// Throughput: sample words without the last mark are taken back to back, one per cycle, while the core is idle.
// After the last word the shared adder runs a sequence: mean divide, two multiplies,
// subtract, multiply, divide and root; a one-sample window in sample mode ends after the
// mean divide. No word is taken during that sequence.
// Reset (synchronous): clears the accumulators, selects sample mode and empties the output.
`timescale 1ns / 1ps

module mean_variance_stddev_core (
   input logic     clock,
   input logic     reset,
   mvs_req_if.sink req_chan,
   mvs_rsp_if.source rsp_chan,
   mvs_csr_if.sink csr_chan
);
   import mvs_pkg::*;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_START    = 4'd1;
   localparam logic [3:0] ST_DIV_MEAN = 4'd2;
   localparam logic [3:0] ST_MUL_NS   = 4'd3;
   localparam logic [3:0] ST_MUL_SQ   = 4'd4;
   localparam logic [3:0] ST_SUB      = 4'd5;
   localparam logic [3:0] ST_MUL_ND   = 4'd6;
   localparam logic [3:0] ST_DIV_VAR  = 4'd7;
   localparam logic [3:0] ST_SQRT     = 4'd8;
   localparam logic [3:0] ST_DONE     = 4'd9;

   logic [3:0] state_ff, state_in;

   // Window accumulators and control register.
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [SQSUM_BITS-1:0]      sumsq_ff, sumsq_in;
   logic                       mode_ff, mode_in;

   // Working registers of the shared unit.
   logic [WORK_BITS-1:0] acc_ff, acc_in;
   logic [WORK_BITS-1:0] opa_ff, opa_in;
   logic [DEN_BITS-1:0]  opb_ff, opb_in;
   logic [WORK_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0]  den_ff, den_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;
   logic                 neg_ff, neg_in;
   logic                 degen_ff, degen_in;
   mean_type             mean_ff, mean_in;
   variance_type         var_ff, var_in;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   mean_type     rsp_mean_ff, rsp_mean_in;
   variance_type rsp_var_ff, rsp_var_in;
   std_dev_type  rsp_sd_ff, rsp_sd_in;
   logic         rsp_degen_ff, rsp_degen_in;

   logic                              req_fire;
   logic                              count_room;
   logic signed [2*SAMPLE_BITS-1:0]   sample_sq;
   logic [SUM_BITS-1:0]               sum_negated;
   logic [MAG_BITS-1:0]               sum_mag;
   logic [REM_BITS-1:0]               rem_shift;
   logic [WORK_BITS-1:0]              alu_x, alu_y;
   logic                              alu_sub;
   logic [WORK_BITS:0]                alu_out;
   logic                              alu_ge;
   logic [WORK_BITS-1:0]              mul_acc;
   logic [WORK_BITS-1:0]              div_rem;
   logic [WORK_BITS-1:0]              div_num;
   logic [WORK_BITS-1:0]              sqrt_rem;
   logic [WORK_BITS-1:0]              sqrt_res;
   logic [MAG_BITS-1:0]               mean_mag;
   logic [MAG_BITS-1:0]               mean_negated;
   logic [VAR_BITS-1:0]               var_sat;
   logic                              iter_last;

   // Handshakes: samples only while idle, control words at any time.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.mean       = rsp_mean_ff;
   assign rsp_chan.variance   = rsp_var_ff;
   assign rsp_chan.std_dev    = rsp_sd_ff;
   assign rsp_chan.degenerate = rsp_degen_ff;

   // Per-sample square and the sum magnitude used by the final sequence.
   assign count_room  = (count_ff < COUNT_BITS'(MAX_SAMPLES));
   assign sample_sq   = req_chan.sample * req_chan.sample;
   assign sum_negated = SUM_BITS'(0) - sum_ff;
   assign sum_mag     = sum_ff[SUM_BITS-1] ? sum_negated[MAG_BITS-1:0] : sum_ff[MAG_BITS-1:0];

   // Operand selection for the one shared add/subtract unit.
   assign rem_shift = {acc_ff[REM_BITS-2:0], num_ff[WORK_BITS-1]};

   always_comb begin
      alu_x   = '0;
      alu_y   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_DIV_MEAN, ST_DIV_VAR: begin
            alu_x   = WORK_BITS'(rem_shift);
            alu_y   = WORK_BITS'(den_ff);
            alu_sub = 1'b1;
         end
         ST_MUL_NS, ST_MUL_SQ, ST_MUL_ND: begin
            alu_x   = acc_ff;
            alu_y   = opa_ff;
            alu_sub = 1'b0;
         end
         ST_SUB: begin
            alu_x   = num_ff;
            alu_y   = acc_ff;
            alu_sub = 1'b1;
         end
         ST_SQRT: begin
            alu_x   = acc_ff;
            alu_y   = opa_ff | WORK_BITS'(opb_ff);
            alu_sub = 1'b1;
         end
         default: begin
            alu_x   = '0;
            alu_y   = '0;
            alu_sub = 1'b0;
         end
      endcase
   end

   // On a subtract the carry out means the first operand was not below the second.
   assign alu_out = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                  + (WORK_BITS+1)'(alu_sub);
   assign alu_ge  = alu_out[WORK_BITS];

   // Step results of the shift-add multiply, restoring divide and bitwise root.
   assign mul_acc  = opb_ff[0] ? alu_out[WORK_BITS-1:0] : acc_ff;
   assign div_rem  = alu_ge ? WORK_BITS'(alu_out[REM_BITS-1:0]) : WORK_BITS'(rem_shift);
   assign div_num  = {num_ff[WORK_BITS-2:0], alu_ge};
   assign sqrt_rem = alu_ge ? alu_out[WORK_BITS-1:0] : acc_ff;
   assign sqrt_res = alu_ge ? ((opa_ff >> 1) | WORK_BITS'(opb_ff)) : (opa_ff >> 1);

   assign mean_mag     = div_num[MAG_BITS-1:0];
   assign mean_negated = MAG_BITS'(0) - mean_mag;
   assign var_sat      = (|div_num[WORK_BITS-1:VAR_BITS]) ? '1 : div_num[VAR_BITS-1:0];
   assign iter_last    = (iter_ff == ITER_BITS'(1));

   // Sequencer and accumulators.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      iter_in      = iter_ff;
      neg_in       = neg_ff;
      degen_in     = degen_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_sd_in    = rsp_sd_ff;
      rsp_degen_in = rsp_degen_ff;

      if (csr_chan.valid && csr_chan.ready) begin
         mode_in = csr_chan.population_mode;
      end

      // A taken result word frees the output register.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // Samples past the window limit are dropped, the last one included.
               if (count_room) begin
                  count_in = count_ff + COUNT_BITS'(1);
                  sum_in   = sum_ff + SUM_BITS'(req_chan.sample);
                  sumsq_in = sumsq_ff + SQSUM_BITS'($unsigned(sample_sq));
               end
               if (req_chan.last) begin
                  state_in = ST_START;
               end
            end
         end

         ST_START: begin
            // The magnitude goes into the upper half so 32 shifts leave the quotient low.
            degen_in = !mode_ff && (count_ff == COUNT_BITS'(1));
            neg_in   = sum_ff[SUM_BITS-1];
            num_in   = {sum_mag, MAG_BITS'(0)};
            acc_in   = '0;
            den_in   = DEN_BITS'(count_ff);
            iter_in  = ITER_BITS'(MAG_BITS);
            var_in   = '0;
            state_in = ST_DIV_MEAN;
         end

         ST_DIV_MEAN: begin
            acc_in  = div_rem;
            num_in  = div_num;
            iter_in = iter_ff - ITER_BITS'(1);
            if (iter_last) begin
               mean_in = neg_ff ? mean_negated[MEAN_BITS-1:0] : mean_mag[MEAN_BITS-1:0];
               if (degen_ff) begin
                  state_in = ST_DONE;
               end else begin
                  acc_in   = '0;
                  opa_in   = WORK_BITS'(sumsq_ff);
                  opb_in   = DEN_BITS'(count_ff);
                  iter_in  = ITER_BITS'(COUNT_BITS);
                  state_in = ST_MUL_NS;
               end
            end
         end

         ST_MUL_NS: begin
            // n times the sum of squares.
            acc_in  = mul_acc;
            opa_in  = opa_ff << 1;
            opb_in  = opb_ff >> 1;
            iter_in = iter_ff - ITER_BITS'(1);
            if (iter_last) begin
               num_in   = mul_acc;
               acc_in   = '0;
               opa_in   = WORK_BITS'(sum_mag);
               opb_in   = DEN_BITS'(sum_mag);
               iter_in  = ITER_BITS'(MAG_BITS);
               state_in = ST_MUL_SQ;
            end
         end

         ST_MUL_SQ: begin
            // Square of the sum magnitude.
            acc_in  = mul_acc;
            opa_in  = opa_ff << 1;
            opb_in  = opb_ff >> 1;
            iter_in = iter_ff - ITER_BITS'(1);
            if (iter_last) begin
               state_in = ST_SUB;
            end
         end

         ST_SUB: begin
            // The numerator floors at zero.
            num_in   = alu_ge ? alu_out[WORK_BITS-1:0] : '0;
            acc_in   = '0;
            opa_in   = WORK_BITS'(count_ff);
            opb_in   = mode_ff ? DEN_BITS'(count_ff) : DEN_BITS'(count_ff - COUNT_BITS'(1));
            iter_in  = ITER_BITS'(COUNT_BITS);
            state_in = ST_MUL_ND;
         end

         ST_MUL_ND: begin
            // Denominator n times d.
            acc_in  = mul_acc;
            opa_in  = opa_ff << 1;
            opb_in  = opb_ff >> 1;
            iter_in = iter_ff - ITER_BITS'(1);
            if (iter_last) begin
               den_in   = mul_acc[DEN_BITS-1:0];
               acc_in   = '0;
               iter_in  = ITER_BITS'(WORK_BITS);
               state_in = ST_DIV_VAR;
            end
         end

         ST_DIV_VAR: begin
            acc_in  = div_rem;
            num_in  = div_num;
            iter_in = iter_ff - ITER_BITS'(1);
            if (iter_last) begin
               // Saturate the quotient and seed the root with the top power of four.
               var_in   = var_sat;
               acc_in   = WORK_BITS'(var_sat);
               opa_in   = '0;
               opb_in   = DEN_BITS'(1) << (VAR_BITS - 2);
               iter_in  = ITER_BITS'(VAR_BITS / 2);
               state_in = ST_SQRT;
            end
         end

         ST_SQRT: begin
            acc_in  = sqrt_rem;
            opa_in  = sqrt_res;
            opb_in  = opb_ff >> 2;
            iter_in = iter_ff - ITER_BITS'(1);
            if (iter_last) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // Load the result word once the output register is free, then clear the window.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_var_in   = var_ff;
               rsp_sd_in    = degen_ff ? '0 : opa_ff[SD_BITS-1:0];
               rsp_degen_in = degen_ff;
               count_in     = '0;
               sum_in       = '0;
               sumsq_in     = '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      iter_ff      <= iter_in;
      neg_ff       <= neg_in;
      degen_ff     <= degen_in;
      mean_ff      <= mean_in;
      var_ff       <= var_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_var_ff   <= rsp_var_in;
      rsp_sd_ff    <= rsp_sd_in;
      rsp_degen_ff <= rsp_degen_in;
   end

endmodule

// ----- verif/mean_variance_stddev_core_tb.sv -----
// Self-checking testbench for the window mean, variance and standard deviation core.
`timescale 1ns / 1ps

module mean_variance_stddev_core_tb;
   import mvs_pkg::*;

   // Run control constants.
   localparam int RESET_CYCLES   = 6;
   localparam int SETTLE_CYCLES  = 200;
   localparam int TAIL_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_AFTER     = 20;
   localparam int HOLD_CYCLES    = 3000;
   localparam int RANDOM_PHASES  = 4;
   localparam int PHASE_WORDS    = 340;
   localparam int PRINT_LIMIT    = 40;

   // One sample word as offered on the input channel.
   typedef struct {
      sample_type sample;
      logic       last;
   } sample_word_type;

   // One result word: the statistics of a closed window.
   typedef struct packed {
      mean_type     mean;
      variance_type variance;
      std_dev_type  std_dev;
      logic         degenerate;
   } window_stats_type;

   logic clock;
   logic reset;

   mvs_req_if req_chan ();
   mvs_rsp_if rsp_chan ();
   mvs_csr_if csr_chan ();

   mean_variance_stddev_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Stimulus and expectation stores.
   sample_word_type  pending_words[$];
   window_stats_type expected_stats[$];

   // Shadow of the accumulators and the mode register.
   logic            pop_mode    = 1'b0;
   int unsigned     win_count   = 0;
   longint          win_sum     = 0;
   longint unsigned win_sqsum   = 0;

   int failures      = 0;
   int stats_checked = 0;
   int send_gap      = 0;
   int stall_left    = 0;
   int quiet_cycles  = 0;
   bit held_off      = 1'b0;
   bit idle_enable   = 1'b1;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Prints one mismatch line, up to a limit, and counts every one.
   task automatic report_mismatch(input string what);
      if (failures < PRINT_LIMIT) begin
         $display("ERROR at %0t: %s", $realtime, what);
      end
      failures++;
   endtask

   // Random gap length: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (!idle_enable || r < 65) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Floor square root by deciding one result bit at a time.
   function automatic longint unsigned floor_sqrt(input longint unsigned value);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Statistics of the window held in the shadow accumulators.
   function automatic window_stats_type close_window();
      window_stats_type stats;
      longint unsigned  n;
      longint unsigned  divisor;
      longint unsigned  magnitude;
      longint unsigned  square;
      longint unsigned  numerator;
      longint unsigned  var_full;
      longint           mean_full;
      n = win_count;
      mean_full = win_sum / longint'(n);
      stats.mean = mean_full[MEAN_BITS-1:0];
      stats.variance = '0;
      stats.std_dev = '0;
      stats.degenerate = 1'b0;
      divisor = pop_mode ? n : n - 1;
      if (divisor == 0) begin
         stats.degenerate = 1'b1;
      end else begin
         magnitude = (win_sum < 0) ? -win_sum : win_sum;
         square = magnitude * magnitude;
         numerator = n * win_sqsum;
         numerator = (numerator > square) ? numerator - square : 64'd0;
         var_full = numerator / (n * divisor);
         if (var_full > 64'hFFFF_FFFF) begin
            var_full = 64'hFFFF_FFFF;
         end
         stats.variance = var_full[VAR_BITS-1:0];
         stats.std_dev = SD_BITS'(floor_sqrt(var_full));
      end
      return stats;
   endfunction

   // Accumulates one accepted word; a marked word closes the window.
   function automatic void take_sample(input sample_type sample, input logic last);
      longint x;
      x = sample;
      if (win_count < MAX_SAMPLES) begin
         win_count++;
         win_sum += x;
         win_sqsum += x * x;
      end
      if (last) begin
         expected_stats.push_back(close_window());
         win_count = 0;
         win_sum = 0;
         win_sqsum = 0;
      end
   endfunction

   function automatic void queue_word(input sample_type sample, input logic last);
      sample_word_type word;
      word.sample = sample;
      word.last = last;
      pending_words.push_back(word);
   endfunction

   // Sample values with extra weight on the ends of the range and near zero.
   function automatic sample_type rand_sample();
      case ($urandom_range(9))
         0: return sample_type'(16'h8000);
         1: return sample_type'(16'h7FFF);
         2: return sample_type'($urandom_range(2) - 1);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Window lengths: mostly short, some long ones.
   function automatic int pick_window_length();
      int r;
      r = $urandom_range(99);
      if (r < 55) begin
         return $urandom_range(1, 4);
      end else if (r < 85) begin
         return $urandom_range(5, 20);
      end else if (r < 97) begin
         return $urandom_range(21, 80);
      end
      return $urandom_range(81, 300);
   endfunction

   // Random windows whose content is constant, two-valued, clustered or spread.
   task automatic queue_random_windows(input int word_budget);
      int         queued;
      int         len;
      int         flavor;
      sample_type base;
      sample_type value;
      queued = 0;
      while (queued < word_budget) begin
         len = pick_window_length();
         flavor = $urandom_range(5);
         base = rand_sample();
         for (int i = 0; i < len; i++) begin
            case (flavor)
               0: value = base;
               1: value = $urandom_range(1) ? sample_type'(16'h7FFF) : sample_type'(16'h8000);
               2: value = base + sample_type'($urandom_range(64)) - sample_type'(32);
               default: value = rand_sample();
            endcase
            queue_word(value, i == len - 1);
         end
         queued += len;
      end
   endtask

   // Waits for all words sent and all results checked, then lets the core settle.
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_chan.valid || expected_stats.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the mode register through its own channel.
   task automatic write_mode(input logic mode);
      csr_chan.valid <= 1'b1;
      csr_chan.population_mode <= mode;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      pop_mode = mode;
   endtask

   // Sample word driver: takes words from the pending queue with random gaps.
   always @(posedge clock) begin : word_driver
      sample_word_type word;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.sample <= '0;
         req_chan.last <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            take_sample(req_chan.sample, req_chan.last);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               word = pending_words.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.sample <= word.sample;
               req_chan.last <= word.last;
               send_gap <= pick_gap();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result ready: random stalls, plus one long hold-off so the core backs up.
   always @(posedge clock) begin : result_ready
      int gap;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
         held_off <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!held_off && stats_checked >= HOLD_AFTER) begin
         held_off <= 1'b1;
         stall_left <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         gap = pick_gap();
         rsp_chan.ready <= (gap == 0);
         if (gap > 1) begin
            stall_left <= gap - 1;
         end
      end
   end

   // Result monitor: checks every accepted word against the oldest expectation.
   always @(posedge clock) begin : stats_monitor
      window_stats_type got;
      window_stats_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.mean = rsp_chan.mean;
         got.variance = rsp_chan.variance;
         got.std_dev = rsp_chan.std_dev;
         got.degenerate = rsp_chan.degenerate;
         if (expected_stats.size() == 0) begin
            report_mismatch($sformatf("unexpected result: mean %0d variance %0d",
                                      got.mean, got.variance));
         end else begin
            want = expected_stats.pop_front();
            if (got.mean !== want.mean || got.variance !== want.variance
                || got.std_dev !== want.std_dev || got.degenerate !== want.degenerate) begin
               report_mismatch($sformatf(
                  "result %0d: mean %0d/%0d variance %0d/%0d std_dev %0d/%0d degenerate %b/%b",
                  stats_checked, got.mean, want.mean, got.variance, want.variance,
                  got.std_dev, want.std_dev, got.degenerate, want.degenerate));
            end
         end
         stats_checked <= stats_checked + 1;
      end
   end

   // Watchdog: ends the run if no channel moves a word for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      reset <= 1'b1;
      csr_chan.valid <= 1'b0;
      csr_chan.population_mode <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sample mode: one-sample windows, extreme spread, flat and truncated means.
      write_mode(1'b0);
      queue_word(sample_type'(16'h8000), 1'b1);
      queue_word(sample_type'(16'h7FFF), 1'b1);
      queue_word(sample_type'(16'h8000), 1'b0);
      queue_word(sample_type'(16'h7FFF), 1'b1);
      queue_word(sample_type'(16'h7FFF), 1'b0);
      queue_word(sample_type'(16'h7FFF), 1'b1);
      queue_word(sample_type'(-1), 1'b0);
      queue_word(sample_type'(-2), 1'b1);
      queue_word(sample_type'(3), 1'b0);
      queue_word(sample_type'(0), 1'b1);
      wait_idle();

      // Population mode: a one-sample window is not degenerate.
      write_mode(1'b1);
      queue_word(sample_type'(12345), 1'b1);
      queue_word(sample_type'(16'h8000), 1'b0);
      queue_word(sample_type'(16'h7FFF), 1'b1);
      queue_word(sample_type'(-5), 1'b0);
      queue_word(sample_type'(7), 1'b0);
      queue_word(sample_type'(100), 1'b1);
      wait_idle();

      // Random windows, switching the mode between phases; the second phase has no gaps.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idle_enable = (p != 1);
         write_mode((p % 2) == 0);
         queue_random_windows(PHASE_WORDS);
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_stats.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_stats.size()));
      end
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
